// ===== design/pcpfa_pkg.sv =====
// Shared constants and codes for the per-CPU page free-list allocator.
`default_nettype none

package pcpfa_pkg;

    // Address and page geometry
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;

    // Request and response stream widths
    localparam int CPU_ID_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [STATUS_W-1:0]  t_status;

    localparam t_cfg_idx REG_REGION_START = 1'd0;
    localparam t_cfg_idx REG_REGION_STOP  = 1'd1;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 32'h8800_0000;

    // Request commands
    localparam logic CMD_FREE  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Response status codes
    localparam t_status STATUS_OK      = 2'd0;
    localparam t_status STATUS_NO_PAGE = 2'd1;
    localparam t_status STATUS_BAD     = 2'd2;

endpackage

`default_nettype wire

// ===== design/per_cpu_page_free_list_allocator_top.sv =====
// Per-CPU LIFO page free lists with stealing, heads and links held in synchronous memories.
// Sequence: the head memory is read at acceptance; a free (or a rejected request) then
// writes its response, an allocate a link read, then head write-back with the response.
// One request at a time, its head and link memory reads in series; a new response waits
// while the last is not taken. A request is taken while the last response waits.
// Reset: all lists empty, region registers at their defaults; the link store is not
// cleared and only entries written by a free are ever read.
`default_nettype none

module per_cpu_page_free_list_allocator_top
    import pcpfa_pkg::*;
#(
    parameter int CPUS  = 8,
    parameter int PAGES = 32768
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration writes
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Request stream
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [0] command, [3:1] cpu_id, [35:4] page_address, [39:36] zero
    input  wire  [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Response stream
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // [31:0] granted_address, [33:32] status, [34] stolen, [39:35] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int PW = $clog2(PAGES);
    localparam int TW = $clog2(PAGES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_LINK = 2'd2;

    // Map a requested cpu number onto an existing list
    function automatic logic [CW-1:0] f_cpu_sel(input logic [CPU_ID_W-1:0] id);
        int v;
        v = int'(id);
        for (int k = 0; k < 8; k++) begin
            if (v >= CPUS) v = v - CPUS;
        end
        return CW'(v);
    endfunction

    // Control and region registers
    logic [1:0]        r_state, n_state;
    logic [CPUS-1:0]   r_nonempty, n_nonempty;
    logic [ADDR_W-1:0] r_region_start, r_region_stop;

    // Request context
    logic              r_cmd;
    logic [CW-1:0]     r_cpu;
    logic [PW-1:0]     r_page;
    logic              r_stolen;
    t_status           r_status;

    // Response register
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_out_grant, n_out_grant;
    t_status           r_out_status, n_out_status;
    logic              r_out_stolen, n_out_stolen;

    // Memories
    logic [TW-1:0]     r_heads [CPUS];
    logic [TW-1:0]     r_links [PAGES];
    logic [TW-1:0]     r_head_q;
    logic [TW-1:0]     r_link_q;

    logic              head_re, head_we, link_re, link_we;
    logic [CW-1:0]     head_raddr;
    logic [TW-1:0]     head_wdata;
    logic [PW-1:0]     link_raddr;
    logic [TW-1:0]     link_wdata;

    // Request fields
    logic                 in_cmd;
    logic [CPU_ID_W-1:0]  in_cpu_id;
    logic [ADDR_W-1:0]    in_addr;
    logic                 accept;
    logic                 out_free;

    assign in_cmd    = i_s_axis_tdata[0];
    assign in_cpu_id = i_s_axis_tdata[CPU_ID_W:1];
    assign in_addr   = i_s_axis_tdata[CPU_ID_W+ADDR_W:CPU_ID_W+1];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Free address checks and page number
    logic [CW-1:0]   req_cpu;
    logic [PFN_W-1:0] pfn_diff;
    logic             free_bad;

    assign req_cpu  = f_cpu_sel(in_cpu_id);
    assign pfn_diff = in_addr[ADDR_W-1:PAGE_SHIFT] - r_region_start[ADDR_W-1:PAGE_SHIFT];
    assign free_bad = (in_addr[PAGE_SHIFT-1:0] != '0) || (in_addr < r_region_start)
                   || (in_addr >= r_region_stop)
                   || ({1'b0, pfn_diff} >= (PFN_W + 1)'(PAGES));

    // Lowest non-empty list for stealing
    logic [CW-1:0] low_cpu;
    logic          any_list;

    always_comb begin
        low_cpu  = '0;
        any_list = 1'b0;
        for (int i = 0; i < CPUS; i++) begin
            if (r_nonempty[i] && !any_list) begin
                low_cpu  = CW'(i);
                any_list = 1'b1;
            end
        end
    end

    // Pick the target list and status at acceptance
    logic [CW-1:0] pick_cpu;
    logic          pick_stolen;
    t_status       pick_status;

    always_comb begin
        pick_cpu    = req_cpu;
        pick_stolen = 1'b0;
        pick_status = STATUS_OK;
        if (in_cmd == CMD_FREE) begin
            if (free_bad) pick_status = STATUS_BAD;
        end else if (!r_nonempty[req_cpu]) begin
            if (any_list) begin
                pick_cpu    = low_cpu;
                pick_stolen = 1'b1;
            end else begin
                pick_status = STATUS_NO_PAGE;
            end
        end
    end

    // Granted address rebuilt from the current region base
    logic [PW-1:0]    head_page;
    logic [PFN_W-1:0] grant_pfn;

    assign head_page = PW'(r_head_q - TW'(1));
    assign grant_pfn = r_region_start[ADDR_W-1:PAGE_SHIFT] + PFN_W'(head_page);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_nonempty   = r_nonempty;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_grant  = r_out_grant;
        n_out_status = r_out_status;
        n_out_stolen = r_out_stolen;
        head_re      = 1'b0;
        head_raddr   = pick_cpu;
        head_we      = 1'b0;
        head_wdata   = TW'(r_page) + TW'(1);
        link_re      = 1'b0;
        link_raddr   = head_page;
        link_we      = 1'b0;
        link_wdata   = r_nonempty[r_cpu] ? r_head_q : '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    head_re = 1'b1;
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (r_status != STATUS_OK || r_cmd == CMD_FREE) begin
                    if (out_free) begin
                        if (r_status == STATUS_OK) begin
                            // push: link page to old head, page becomes head
                            link_we           = 1'b1;
                            head_we           = 1'b1;
                            n_nonempty[r_cpu] = 1'b1;
                        end
                        n_out_valid  = 1'b1;
                        n_out_grant  = '0;
                        n_out_status = r_status;
                        n_out_stolen = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    // pop: fetch the head's successor
                    link_re      = 1'b1;
                    n_out_grant  = r_out_grant;
                    n_state      = ST_LINK;
                end
            end
            ST_LINK: begin
                if (out_free) begin
                    head_wdata        = r_link_q;
                    head_we           = 1'b1;
                    n_nonempty[r_cpu] = (r_link_q != '0);
                    n_out_valid       = 1'b1;
                    n_out_grant       = {grant_pfn, {PAGE_SHIFT{1'b0}}};
                    n_out_status      = STATUS_OK;
                    n_out_stolen      = r_stolen;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_nonempty     <= '0;
            r_out_valid    <= 1'b0;
            r_region_start <= REGION_START_RST;
            r_region_stop  <= REGION_STOP_RST;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REGION_START: r_region_start <= i_cfg_wdata;
                    REG_REGION_STOP:  r_region_stop  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Request context and response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= in_cmd;
            r_cpu    <= pick_cpu;
            r_page   <= PW'(pfn_diff);
            r_stolen <= pick_stolen;
            r_status <= pick_status;
        end
        r_out_grant  <= n_out_grant;
        r_out_status <= n_out_status;
        r_out_stolen <= n_out_stolen;
    end

    // List head memory
    always_ff @(posedge i_clk) begin
        if (head_re) r_head_q <= r_heads[head_raddr];
        if (head_we) r_heads[r_cpu] <= head_wdata;
    end

    // Next-link memory
    always_ff @(posedge i_clk) begin
        if (link_re) r_link_q <= r_links[link_raddr];
        if (link_we) r_links[r_page] <= link_wdata;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - ADDR_W - STATUS_W - 1)'(0),
                              r_out_stolen, r_out_status, r_out_grant};

endmodule

`default_nettype wire
